// ===== src/mtce_pkg.sv =====
// Package for the MIDI track controller extractor.
// Holds parse phase codes, status byte constants, field widths and configuration register indexes.
// No dependencies.
package mtce_pkg;

  localparam int TICK_W  = 31;
  localparam int LEN_W   = 32;
  localparam int PHASE_W = 3;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // parse phases
  localparam logic [PHASE_W-1:0] PH_DELTA     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STATUS    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_META_TYPE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LENGTH    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SKIP      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA      = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DEAD      = 3'd6;

  // status and meta codes
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [3:0] KIND_CC     = 4'hB;
  localparam logic [3:0] KIND_PROG   = 4'hC;
  localparam logic [3:0] KIND_PRESS  = 4'hD;
  localparam logic [3:0] KIND_SYSTEM = 4'hF;

  // configuration register indexes
  localparam logic CFG_LISTEN_CHANNEL    = 1'b0;
  localparam logic CFG_CONTROLLER_NUMBER = 1'b1;

endpackage

// ===== src/midi_track_controller_extractor_top.sv =====
// Top level of the MIDI track controller extractor.
// Parses track body bytes and reports matching control changes and track end ticks.
// Depends on mtce_pkg.

// Takes one track body byte per clock and, with the output free, sustains one byte per
// cycle; an accepted byte passes the input register, then the parse step into the result
// register; a stalled result output holds it in the input register. The rate is set by
// the parse state update, one short step per byte: a variable-length shift, a saturating
// 31-bit tick add and a 32-bit skip count. Only bytes that complete a matching nonzero
// control change, or that are flagged last of track, produce a result transaction; all
// others are consumed silently.
// Configuration writes are always ready and take effect on the next byte processed.
module midi_track_controller_extractor_top
  import mtce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  // byte input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              first_of_track,
  input  logic              last_of_track,
  input  logic              first_of_file,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic              event_found,
  output logic [TICK_W-1:0] event_tick,
  output logic [6:0]        event_value,
  output logic              track_done,
  output logic [TICK_W-1:0] max_tick_seen,
  output logic [TICK_W-1:0] end_tick_seen
);

  // configuration
  logic [3:0] listen_channel;
  logic [6:0] controller_number;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first_track;
  logic       s1_last;
  logic       s1_first_file;

  // parse state
  logic [PHASE_W-1:0] parse_phase;
  logic [LEN_W-1:0]   length_accumulator;
  logic [TICK_W-1:0]  absolute_tick;
  logic [7:0]         running_status;
  logic               running_valid;
  logic [LEN_W-1:0]   skip_remaining;
  logic [1:0]         data_remaining;
  logic               message_matches;
  logic [7:0]         held_controller;
  logic [TICK_W-1:0]  max_tick;
  logic [TICK_W-1:0]  end_tick;

  logic [PHASE_W-1:0] parse_phase_next;
  logic [LEN_W-1:0]   length_accumulator_next;
  logic [TICK_W-1:0]  absolute_tick_next;
  logic [7:0]         running_status_next;
  logic               running_valid_next;
  logic [LEN_W-1:0]   skip_remaining_next;
  logic [1:0]         data_remaining_next;
  logic               message_matches_next;
  logic [7:0]         held_controller_next;
  logic [TICK_W-1:0]  max_tick_next;
  logic [TICK_W-1:0]  end_tick_next;

  logic               found;
  logic [6:0]         value;
  logic               produce;
  logic               fire;
  logic               accept;

  logic [LEN_W-1:0]   len_shift;
  logic [TICK_W:0]    tick_sum;
  logic [LEN_W-1:0]   skip_dec;
  logic [7:0]         status;
  logic               do_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel    <= 4'd0;
      controller_number <= 7'd11;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LISTEN_CHANNEL:    listen_channel    <= cfg_data[3:0];
        CFG_CONTROLLER_NUMBER: controller_number <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // the parse step runs unless a held result blocks the output register
  assign fire     = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte        <= data_byte;
      s1_first_track <= first_of_track;
      s1_last        <= last_of_track;
      s1_first_file  <= first_of_file;
    end
  end

  always_comb begin
    max_tick_next = s1_first_file ? '0 : max_tick;
    end_tick_next = s1_first_file ? '0 : end_tick;
    if (s1_first_track) begin
      parse_phase_next        = PH_DELTA;
      length_accumulator_next = '0;
      absolute_tick_next      = '0;
      running_status_next     = 8'd0;
      running_valid_next      = 1'b0;
      skip_remaining_next     = '0;
      data_remaining_next     = 2'd0;
      message_matches_next    = 1'b0;
      held_controller_next    = 8'd0;
    end else begin
      parse_phase_next        = parse_phase;
      length_accumulator_next = length_accumulator;
      absolute_tick_next      = absolute_tick;
      running_status_next     = running_status;
      running_valid_next      = running_valid;
      skip_remaining_next     = skip_remaining;
      data_remaining_next     = data_remaining;
      message_matches_next    = message_matches;
      held_controller_next    = held_controller;
    end

    found     = 1'b0;
    value     = 7'd0;
    do_data   = 1'b0;
    len_shift = {length_accumulator_next[LEN_W-8:0], s1_byte[6:0]};
    tick_sum  = {1'b0, absolute_tick_next} + len_shift[TICK_W:0];
    skip_dec  = skip_remaining_next - LEN_W'(1);
    status    = s1_byte[7] ? s1_byte : running_status_next;

    unique case (parse_phase_next)
      PH_DELTA: begin
        length_accumulator_next = len_shift;
        if (!s1_byte[7] || s1_last) begin
          // saturating add; bit 31 of the length also forces saturation
          if (tick_sum[TICK_W] || len_shift[LEN_W-1]) begin
            absolute_tick_next = TICK_MAX;
          end else begin
            absolute_tick_next = tick_sum[TICK_W-1:0];
          end
          if (absolute_tick_next > max_tick_next) begin
            max_tick_next = absolute_tick_next;
          end
          length_accumulator_next = '0;
          if (!s1_byte[7]) begin
            parse_phase_next = PH_STATUS;
          end
        end
      end
      PH_STATUS: begin
        if (!s1_byte[7] && !running_valid_next) begin
          parse_phase_next = PH_DEAD;
        end else begin
          if (status != ST_SYSEX && status != ST_ESCAPE && status != ST_META) begin
            running_status_next = status;
            running_valid_next  = 1'b1;
          end
          if (status == ST_META) begin
            parse_phase_next = PH_META_TYPE;
          end else if (status == ST_SYSEX || status == ST_ESCAPE) begin
            length_accumulator_next = '0;
            parse_phase_next        = PH_LENGTH;
          end else if (status[7:4] == KIND_SYSTEM) begin
            parse_phase_next = PH_DEAD;
          end else begin
            data_remaining_next  = (status[7:4] == KIND_PROG || status[7:4] == KIND_PRESS)
                                   ? 2'd1 : 2'd2;
            message_matches_next = (status[7:4] == KIND_CC) &&
                                   (status[3:0] == listen_channel);
            held_controller_next = 8'd0;
            parse_phase_next     = PH_DATA;
            // running status: this byte is already the first data byte
            do_data              = !s1_byte[7];
          end
        end
      end
      PH_META_TYPE: begin
        if (s1_byte == META_EOT) begin
          if (absolute_tick_next > end_tick_next) begin
            end_tick_next = absolute_tick_next;
          end
          parse_phase_next = PH_DEAD;
        end else begin
          length_accumulator_next = '0;
          parse_phase_next        = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (!s1_byte[7]) begin
          skip_remaining_next     = len_shift;
          length_accumulator_next = '0;
          parse_phase_next        = (len_shift == '0) ? PH_DELTA : PH_SKIP;
        end else begin
          length_accumulator_next = len_shift;
        end
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == '0) begin
          parse_phase_next = PH_DELTA;
        end
      end
      PH_DATA: begin
        do_data = 1'b1;
      end
      default: ;
    endcase

    if (do_data) begin
      if (message_matches_next && data_remaining_next == 2'd2) begin
        held_controller_next = s1_byte;
      end else if (message_matches_next && data_remaining_next == 2'd1) begin
        if (held_controller_next == {1'b0, controller_number} &&
            !s1_byte[7] && s1_byte[6:0] != 7'd0) begin
          found = 1'b1;
          value = s1_byte[6:0];
        end
      end
      data_remaining_next = data_remaining_next - 2'd1;
      if (data_remaining_next == 2'd0) begin
        parse_phase_next = PH_DELTA;
      end
    end

    produce = found || s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_DELTA;
      length_accumulator <= '0;
      absolute_tick      <= '0;
      running_status     <= 8'd0;
      running_valid      <= 1'b0;
      skip_remaining     <= '0;
      data_remaining     <= 2'd0;
      message_matches    <= 1'b0;
      held_controller    <= 8'd0;
      max_tick           <= '0;
      end_tick           <= '0;
    end else if (fire) begin
      parse_phase        <= parse_phase_next;
      length_accumulator <= length_accumulator_next;
      absolute_tick      <= absolute_tick_next;
      running_status     <= running_status_next;
      running_valid      <= running_valid_next;
      skip_remaining     <= skip_remaining_next;
      data_remaining     <= data_remaining_next;
      message_matches    <= message_matches_next;
      held_controller    <= held_controller_next;
      max_tick           <= max_tick_next;
      end_tick           <= end_tick_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      event_found   <= found;
      event_tick    <= found ? absolute_tick_next : '0;
      event_value   <= value;
      track_done    <= s1_last;
      max_tick_seen <= max_tick_next;
      end_tick_seen <= end_tick_next;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for midi_track_controller_extractor_top: directed and random track byte streams,
// each result checked against an in-bench parser model. Depends on mtce_pkg and the RTL top.
module tb_top;
  import mtce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] b;
    logic       fot;
    logic       lot;
    logic       fof;
  } track_byte_t;

  typedef struct packed {
    logic              found;
    logic [TICK_W-1:0] tick;
    logic [6:0]        value;
    logic              done;
    logic [TICK_W-1:0] max_t;
    logic [TICK_W-1:0] end_t;
  } track_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [7:0]        cfg_data = 8'h00;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        data_byte = 8'h00;
  logic              first_of_track = 1'b0;
  logic              last_of_track = 1'b0;
  logic              first_of_file = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              event_found;
  logic [TICK_W-1:0] event_tick;
  logic [6:0]        event_value;
  logic              track_done;
  logic [TICK_W-1:0] max_tick_seen;
  logic [TICK_W-1:0] end_tick_seen;

  midi_track_controller_extractor_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .first_of_track(first_of_track), .last_of_track(last_of_track),
    .first_of_file(first_of_file),
    .out_valid(out_valid), .out_stall(out_stall), .event_found(event_found),
    .event_tick(event_tick), .event_value(event_value), .track_done(track_done),
    .max_tick_seen(max_tick_seen), .end_tick_seen(end_tick_seen)
  );

  always #5 clk = ~clk;

  // parser model state
  logic [3:0]        chan_cfg = 4'd0;
  logic [6:0]        ctrl_cfg = 7'd11;
  logic [PHASE_W-1:0] phase = PH_DELTA;
  logic [31:0]       len_acc = '0;
  logic [TICK_W-1:0] abs_tick = '0;
  logic [7:0]        run_status = '0;
  logic              run_valid = 1'b0;
  logic [31:0]       skip_left = '0;
  logic [1:0]        data_left = '0;
  logic              cc_match = 1'b0;
  logic [7:0]        held_ctrl = '0;
  logic [TICK_W-1:0] max_tick = '0;
  logic [TICK_W-1:0] end_tick = '0;

  track_result_t pending_results[$];
  track_byte_t   track_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int parsed_bytes = 0;
  int tracks_sent = 0;
  int results_seen = 0;
  int events_seen = 0;

  function automatic void clear_track_state();
    phase = PH_DELTA;
    len_acc = '0;
    abs_tick = '0;
    run_status = '0;
    run_valid = 1'b0;
    skip_left = '0;
    data_left = '0;
    cc_match = 1'b0;
    held_ctrl = '0;
  endfunction

  function automatic void fold_delta();
    logic [32:0] sum;
    sum = {2'b00, abs_tick} + {1'b0, len_acc};
    abs_tick = (sum > {2'b00, TICK_MAX}) ? TICK_MAX : sum[TICK_W-1:0];
    if (abs_tick > max_tick) max_tick = abs_tick;
    len_acc = '0;
  endfunction

  // one data byte of a channel message; 1 when a matching nonzero CC completes
  function automatic logic take_data(input logic [7:0] b, output logic [6:0] val);
    logic hit;
    hit = 1'b0;
    val = '0;
    if (cc_match && data_left == 2'd2) begin
      held_ctrl = b;
    end else if (cc_match && data_left == 2'd1) begin
      if (held_ctrl == {1'b0, ctrl_cfg} && b >= 8'd1 && b <= 8'h7F) begin
        val = b[6:0];
        hit = 1'b1;
      end
    end
    data_left = data_left - 2'd1;
    if (data_left == 2'd0) phase = PH_DELTA;
    return hit;
  endfunction

  function automatic logic parse_byte(input track_byte_t s, output track_result_t r);
    logic [7:0] status;
    logic       found;
    logic [6:0] val;
    logic       consumed;
    found = 1'b0;
    val = '0;
    if (s.fof) begin
      max_tick = '0;
      end_tick = '0;
    end
    if (s.fot) clear_track_state();
    if (phase != PH_DEAD) parsed_bytes++;
    case (phase)
      PH_DELTA: begin
        len_acc = {len_acc[24:0], s.b[6:0]};
        if (!s.b[7]) begin
          fold_delta();
          phase = PH_STATUS;
        end else if (s.lot) begin
          fold_delta();
        end
      end
      PH_STATUS: begin
        consumed = s.b[7];
        if (!consumed && !run_valid) begin
          phase = PH_DEAD;
        end else begin
          status = consumed ? s.b : run_status;
          if (status != ST_SYSEX && status != ST_ESCAPE && status != ST_META) begin
            run_status = status;
            run_valid = 1'b1;
          end
          if (status == ST_META) begin
            phase = PH_META_TYPE;
          end else if (status == ST_SYSEX || status == ST_ESCAPE) begin
            len_acc = '0;
            phase = PH_LENGTH;
          end else if (status[7:4] == KIND_SYSTEM) begin
            phase = PH_DEAD;
          end else begin
            data_left = (status[7:4] == KIND_PROG || status[7:4] == KIND_PRESS) ? 2'd1 : 2'd2;
            cc_match = (status[7:4] == KIND_CC) && (status[3:0] == chan_cfg);
            held_ctrl = '0;
            phase = PH_DATA;
            // running status: this byte is already the first data byte
            if (!consumed) found = take_data(s.b, val);
          end
        end
      end
      PH_META_TYPE: begin
        if (s.b == META_EOT) begin
          if (abs_tick > end_tick) end_tick = abs_tick;
          phase = PH_DEAD;
        end else begin
          len_acc = '0;
          phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc = {len_acc[24:0], s.b[6:0]};
        if (!s.b[7]) begin
          skip_left = len_acc;
          len_acc = '0;
          phase = (skip_left == 0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) phase = PH_DELTA;
      end
      PH_DATA: begin
        found = take_data(s.b, val);
      end
      default: begin
      end
    endcase
    r.found = found;
    r.tick = found ? abs_tick : '0;
    r.value = found ? val : '0;
    r.done = s.lot;
    r.max_t = max_tick;
    r.end_t = end_tick;
    return found || s.lot;
  endfunction

  // receiver side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    track_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_found", 32'(want.found), 32'(event_found));
        check_field("event_tick", 32'(want.tick), 32'(event_tick));
        check_field("event_value", 32'(want.value), 32'(event_value));
        check_field("track_done", 32'(want.done), 32'(track_done));
        check_field("max_tick_seen", 32'(want.max_t), 32'(max_tick_seen));
        check_field("end_tick_seen", 32'(want.end_t), 32'(end_tick_seen));
        results_seen++;
        if (want.found) events_seen++;
      end
    end
  end

  task automatic send_byte(input track_byte_t s);
    track_result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= s.b;
    first_of_track <= s.fot;
    last_of_track <= s.lot;
    first_of_file <= s.fof;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (parse_byte(s, r)) pending_results.insert(pending_results.size(), r);
  endtask

  function automatic void push(input logic [7:0] b);
    track_q.insert(track_q.size(), '{b: b, fot: 1'b0, lot: 1'b0, fof: 1'b0});
  endfunction

  task automatic send_track(input logic fot, input logic fof);
    track_q[0].fot = fot;
    track_q[0].fof = track_q[0].fof | fof;
    track_q[track_q.size()-1].lot = 1'b1;
    foreach (track_q[i]) send_byte(track_q[i]);
    track_q.delete();
    tracks_sent++;
  endtask

  // everything sent has been parsed and its results collected
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LISTEN_CHANNEL) chan_cfg = d[3:0];
    else ctrl_cfg = d[6:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] ch, input logic [6:0] ctrl);
    logic [3:0] junk;
    junk = 4'($urandom_range(15));
    wait_idle();
    write_reg(CFG_LISTEN_CHANNEL, {junk, ch});
    write_reg(CFG_CONTROLLER_NUMBER, {junk[0], ctrl});
  endtask

  function automatic void push_delta();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      push(8'($urandom_range(127)));
    end else if (r < 80) begin
      push(8'(8'h80 | $urandom_range(127)));
      push(8'($urandom_range(127)));
    end else begin
      // 97+: five bytes, the top bits fall off the 32-bit accumulator
      repeat ((r < 97) ? $urandom_range(2, 3) : 4) push(8'(8'h80 | $urandom_range(127)));
      push(8'($urandom_range(127)));
    end
  endfunction

  function automatic void push_len(input int len);
    if ($urandom_range(4) == 0) push(8'h80);
    push(8'(len));
    repeat (len) push(8'($urandom_range(255)));
  endfunction

  function automatic void gen_track();
    int n_ev;
    int kind;
    logic [7:0] st;
    logic cc_running;
    cc_running = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) push(8'($urandom_range(255)));
      return;
    end
    n_ev = $urandom_range(1, 10);
    for (int e = 0; e < n_ev; e++) begin
      push_delta();
      kind = $urandom_range(99);
      if (kind < 35) begin
        if (!cc_running || $urandom_range(9) < 7) push({KIND_CC, chan_cfg});
        cc_running = 1'b1;
        push(($urandom_range(4) != 0) ? {1'b0, ctrl_cfg} : 8'($urandom_range(255)));
        push(8'(($urandom_range(6) != 0) ? $urandom_range(127) : $urandom_range(128, 255)));
      end else if (kind < 45) begin
        push({KIND_CC, 4'($urandom_range(15))});
        cc_running = 1'b0;
        push(8'($urandom_range(127)));
        push(8'($urandom_range(127)));
      end else if (kind < 60) begin
        st = {4'($urandom_range(8, 14)), 4'($urandom_range(15))};
        if (st[7:4] == KIND_CC || st[7:4] == KIND_PROG || st[7:4] == KIND_PRESS) st[7:4] = 4'h9;
        push(st);
        cc_running = 1'b0;
        push(8'($urandom_range(127)));
        push(8'($urandom_range(127)));
      end else if (kind < 68) begin
        push({($urandom_range(1) != 0) ? KIND_PROG : KIND_PRESS, 4'($urandom_range(15))});
        cc_running = 1'b0;
        push(8'($urandom_range(127)));
      end else if (kind < 76) begin
        // data bytes under whatever running status is live
        push(8'($urandom_range(127)));
        push(8'($urandom_range(127)));
      end else if (kind < 84) begin
        push(($urandom_range(1) != 0) ? ST_SYSEX : ST_ESCAPE);
        push_len($urandom_range(5));
      end else if (kind < 92) begin
        push(ST_META);
        st = 8'($urandom_range(127));
        push((st == META_EOT) ? 8'h01 : st);
        push_len($urandom_range(5));
      end else if (kind < 95) begin
        st = 8'($urandom_range(8'hF1, 8'hFE));
        push((st == ST_ESCAPE) ? 8'hF1 : st);
        repeat ($urandom_range(3)) push(8'($urandom_range(255)));
      end else begin
        break;
      end
    end
    if ($urandom_range(1) != 0) begin
      push(8'h00);
      push(ST_META);
      push(META_EOT);
      push(8'h00);
    end else if ($urandom_range(5) == 0 && track_q.size() > 2) begin
      repeat ($urandom_range(1, 2)) void'(track_q.pop_back());
    end
  endfunction

  task automatic test_parse_basics();
    // CC at tick 0, running status with value 0, five-byte delta that saturates,
    // controller byte with top bit set, end-of-track then a trailing byte
    push(8'h00); push(8'hB0); push(8'h0B); push(8'h7F);
    push(8'h81); push(8'h00); push(8'h0B); push(8'h00);
    push(8'h8F); push(8'hFF); push(8'hFF); push(8'hFF); push(8'h7F);
    push(8'hB0); push(8'h8B); push(8'h05);
    push(8'h00); push(ST_META); push(META_EOT); push(8'hFF);
    send_track(1'b1, 1'b1);
  endtask

  task automatic test_abandon_cases();
    // data byte with no running status
    push(8'h40); push(8'h20); push(8'h00);
    send_track(1'b1, 1'b0);
    // unknown status, then file clear on a byte that is not first of track
    push(8'h00); push(8'hF5); push(8'h00);
    track_q[2].fof = 1'b1;
    send_track(1'b1, 1'b0);
  endtask

  task automatic test_track_boundaries();
    // CC cut short by the track end, then the value arrives without first_of_track
    push(8'h00); push(8'hB0); push(8'h0B);
    send_track(1'b1, 1'b0);
    push(8'h05);
    send_track(1'b0, 1'b0);
    // track ends inside a delta time
    push(8'h83);
    send_track(1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle);
    int start;
    send_idle_pct = s_idle;
    recv_stall_pct = r_idle;
    for (int sub = 0; sub < 3; sub++) begin
      if (sub == 0) set_config(4'd15, 7'd127);
      else if (sub == 1) set_config(4'd0, 7'd0);
      else set_config(4'($urandom_range(15)),
                      ($urandom_range(1) != 0) ? 7'd11 : 7'($urandom_range(127)));
      start = parsed_bytes;
      while (parsed_bytes - start < 55) begin
        gen_track();
        if (track_q.size() == 0) push(8'($urandom_range(255)));
        if ($urandom_range(19) == 0) track_q[$urandom_range(track_q.size() - 1)].fof = 1'b1;
        send_track($urandom_range(9) != 0, $urandom_range(4) == 0);
      end
    end
  endtask

  initial begin
    send_idle_pct = 21;
    recv_stall_pct = 77;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_parse_basics();
    test_abandon_cases();
    test_track_boundaries();
    test_random_traffic(21, 77);
    test_random_traffic(77, 21);
    test_random_traffic(0, 0);
    wait_idle();
    $display("%0d bytes in %0d tracks, %0d results checked, %0d control changes found",
             bytes_sent, tracks_sent, results_seen, events_seen);
    $display("covered running status, sysex/meta skips, abandoned tracks, tick saturation");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
